// ----- rtl/rrfs_pkg.sv -----
// ----------------------------------------------------------------------------
// rrfs_pkg
// Types, codes and helpers shared by the run queue scheduler and its checker.
// ----------------------------------------------------------------------------
package rrfs_pkg;

   // Thread id and configuration widths
   localparam int ID_W       = 8;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CAP_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // Request kinds
   localparam logic [FUNC_W-1:0] FUNC_ENTER = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LEAVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_NEXT  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DUP     = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RR_MODE  = 1'd1;

   // Configuration reset values
   localparam logic [CAP_W-1:0] CAP_RESET     = 5'd16;
   localparam logic             RR_MODE_RESET = 1'b1;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   thread_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     selected_id;
   } rsp_type;

   // Build a result from status and selected id
   function automatic rsp_type mk_rsp(input logic [STATUS_W-1:0] status,
                                      input logic [ID_W-1:0] sel);
      rsp_type r;
      r.status      = status;
      r.selected_id = sel;
      return r;
   endfunction

endpackage

// ----- rtl/run_queue_rr_fifo_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// run_queue_rr_fifo_scheduler_core
// Bounded run queue of thread ids with FIFO or round-robin worker pick.
// ----------------------------------------------------------------------------
//  channel   ports                           handshake
//  request   start, busy, req_item           taken when start && !busy
//  result    rsp_valid, rsp_item             one-cycle strobe, no back-pressure
//  config    csr_we, csr_index, csr_wdata    written when csr_we
//
//  One request at a time. The queue lives in a single-port-read slot memory,
//  so work is bounded by that port: a scan reads the queued ids one at a
//  time, closing a gap after position p reads and moves each later entry
//  down, and the head is read through the registered read port. Reset is
//  synchronous; no memory clearing pass is needed. Results cannot be stalled.
// ----------------------------------------------------------------------------
module run_queue_rr_fifo_scheduler_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  rrfs_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   output rrfs_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_we,
   input  logic [rrfs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rrfs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import rrfs_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int KW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [KW-1:0] DEPTH_K = KW'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_HEAD,
      S_HEAD_WAIT
   } state_type;

   state_type         state_ff, state_in;
   logic [FUNC_W-1:0] op_ff, op_in;
   logic [ID_W-1:0]   tgt_ff, tgt_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [ID_W-1:0]   run_id_ff, run_id_in;
   logic              run_vld_ff, run_vld_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic              rr_mode_ff, rr_mode_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [ID_W-1:0]   mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [ID_W-1:0]   rd_data;

   logic              issue_more;
   logic              hit;
   logic              full;
   logic [KW-1:0]     count_k;
   logic [KW-1:0]     cap_nz;
   logic [CW-1:0]     last_idx;

   rrfs_slot_mem #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW),
      .DW    (ID_W)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   // Queue status terms
   always_comb begin
      issue_more = (issue_ff < count_ff);
      hit        = rd_vld_ff && (rd_data == tgt_ff);
      count_k    = KW'(count_ff);
      cap_nz     = (cap_ff == '0) ? KW'(1) : KW'(cap_ff);
      full       = (count_k >= DEPTH_K) || (count_k >= cap_nz);
      last_idx   = count_ff - CW'(1);
   end

   // Next state: scan, compact, rotate and pick
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tgt_in       = tgt_ff;
      count_in     = count_ff;
      run_id_in    = run_id_ff;
      run_vld_in   = run_vld_ff;
      cap_in       = cap_ff;
      rr_mode_in   = rr_mode_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      // Take configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: cap_in     = csr_wdata[CAP_W-1:0];
            CSR_RR_MODE:  rr_mode_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_item.func;
               tgt_in   = req_item.thread_id;
               issue_in = '0;
               case (req_item.func)
                  FUNC_ENTER, FUNC_LEAVE: begin
                     state_in = S_SCAN;
                  end
                  FUNC_NEXT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = mk_rsp(ST_EMPTY, '0);
                     end else if (rr_mode_ff && run_vld_ff && (count_ff > CW'(1))) begin
                        tgt_in   = run_id_ff;
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_HEAD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = mk_rsp(ST_OK, '0);
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (hit) begin
               // Found the id at rd_idx_ff
               if (op_ff == FUNC_ENTER) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = mk_rsp(ST_DUP, '0);
                  state_in     = S_IDLE;
               end else begin
                  issue_in = CW'(rd_idx_ff) + CW'(1);
                  state_in = S_SHIFT;
               end
            end else if (issue_more) begin
               // Advance the search one slot
               mem_re    = 1'b1;
               mem_raddr = issue_ff[AW-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[AW-1:0];
               issue_in  = issue_ff + CW'(1);
            end else begin
               // Search exhausted, id absent
               case (op_ff)
                  FUNC_ENTER: begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                     if (full) begin
                        rsp_in = mk_rsp(ST_FULL, '0);
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = tgt_ff;
                        count_in  = count_ff + CW'(1);
                        rsp_in    = mk_rsp(ST_OK, '0);
                     end
                  end
                  FUNC_LEAVE: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = mk_rsp(ST_MISSING, '0);
                     state_in     = S_IDLE;
                  end
                  default: begin
                     state_in = S_HEAD;
                  end
               endcase
            end
         end

         S_SHIFT: begin
            // Move each later entry down one slot
            if (rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_idx_ff - AW'(1);
               mem_wdata = rd_data;
            end
            if (issue_more) begin
               mem_re    = 1'b1;
               mem_raddr = issue_ff[AW-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[AW-1:0];
               issue_in  = issue_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               if (op_ff == FUNC_LEAVE) begin
                  count_in     = last_idx;
                  rsp_valid_in = 1'b1;
                  rsp_in       = mk_rsp(ST_OK, '0);
                  state_in     = S_IDLE;
               end else begin
                  // Append the rotated id at the tail
                  mem_we    = 1'b1;
                  mem_waddr = last_idx[AW-1:0];
                  mem_wdata = tgt_ff;
                  state_in  = S_HEAD;
               end
            end
         end

         S_HEAD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_in  = S_HEAD_WAIT;
         end

         S_HEAD_WAIT: begin
            if (rr_mode_ff) begin
               run_id_in  = rd_data;
               run_vld_in = 1'b1;
            end
            rsp_valid_in = 1'b1;
            rsp_in       = mk_rsp(ST_OK, rd_data);
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      tgt_ff    <= tgt_in;
      issue_ff  <= issue_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         run_id_ff    <= '0;
         run_vld_ff   <= 1'b0;
         cap_ff       <= CAP_RESET;
         rr_mode_ff   <= RR_MODE_RESET;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_id_ff    <= run_id_in;
         run_vld_ff   <= run_vld_in;
         cap_ff       <= cap_in;
         rr_mode_ff   <= rr_mode_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- rtl/rrfs_slot_mem.sv -----
// ----------------------------------------------------------------------------
// rrfs_slot_mem
// Queue slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rrfs_slot_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] slot_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write the slot, register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rrfs_checker.sv -----
// ----------------------------------------------------------------------------
// rrfs_checker
// Port-level checks on the run queue scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrfs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input rrfs_pkg::req_type               req_item,
   input logic                            rsp_valid,
   input rrfs_pkg::rsp_type               rsp_item
);

   import rrfs_pkg::*;

   // A failed request never carries a selected id
   a_fail_no_sel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != ST_OK) |-> rsp_item.selected_id == '0)
      else $error("non-ok result carries a selected id");

   // A result only follows an accepted request or ongoing work
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("result without a request");

   // Busy only rises after a request is taken
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // An unused request code answers ok with no id on the next cycle
   a_unused_func: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.func != FUNC_ENTER) && (req_item.func != FUNC_LEAVE)
      && (req_item.func != FUNC_NEXT)
      |=> rsp_valid && (rsp_item.status == ST_OK) && (rsp_item.selected_id == '0))
      else $error("unused request code not answered at once");

   // An enter always searches the queue first
   a_enter_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.func == FUNC_ENTER) |=> busy)
      else $error("enter did not start a search");

endmodule

bind run_queue_rr_fifo_scheduler_core rrfs_checker u_rrfs_checker (.*);

// ----- tb/run_queue_rr_fifo_scheduler_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_queue_rr_fifo_scheduler_core_tb
// Self-checking bench for the run queue scheduler. A queue-fed driver issues
// enter, leave and next requests with random gaps. A monitor mirrors the
// queue, the running id and both registers. It checks every result strobe
// against its own prediction, in order. Short directed phases come first,
// then random phases across capacity and mode settings.
// ----------------------------------------------------------------------------
module run_queue_rr_fifo_scheduler_core_tb;
   import rrfs_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int TIMEOUT_CYCLES = 600000;
   localparam int RAND_PHASES    = 12;
   localparam int PHASE_ITEMS    = 120;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_item  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_item;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Mirror of the run queue and registers
   logic [ID_W-1:0]  rq_slots [QUEUE_DEPTH];
   int               rq_count;
   logic [ID_W-1:0]  run_id;
   logic             run_valid;
   logic [CAP_W-1:0] cfg_capacity;
   logic             cfg_rr_mode;

   req_type pending_reqs  [$];
   rsp_type expected_rsps [$];
   int      issued_count   = 0;
   int      accepted_count = 0;
   int      fail_count     = 0;
   int      cycle_count    = 0;
   int      gap_left       = 0;
   bit      gaps_on        = 1'b1;
   bit      req_taken      = 1'b0;

   run_queue_rr_fifo_scheduler_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Position of an id in the mirrored queue, -1 when absent
   function automatic int slot_of(input logic [ID_W-1:0] id);
      for (int i = 0; i < rq_count; i++) begin
         if (rq_slots[i] == id) return i;
      end
      return -1;
   endfunction

   // Remove one entry and close the gap, keeping order
   function automatic void drop_slot(input int pos);
      for (int i = pos; i + 1 < rq_count; i++) rq_slots[i] = rq_slots[i + 1];
      rq_count--;
   endfunction

   // Advance the mirror by one request and build the result it should give
   task automatic apply_request(input req_type r, output rsp_type e);
      int         pos;
      logic [4:0] cap;
      e.status      = ST_OK;
      e.selected_id = '0;
      cap = cfg_capacity;
      if (cap == 0) cap = 5'd1;
      if (cap > QUEUE_DEPTH) cap = 5'(QUEUE_DEPTH);
      case (r.func)
         FUNC_ENTER: begin
            if (slot_of(r.thread_id) >= 0) begin
               e.status = ST_DUP;
            end else if (rq_count >= cap) begin
               e.status = ST_FULL;
            end else begin
               rq_slots[rq_count] = r.thread_id;
               rq_count++;
            end
         end
         FUNC_LEAVE: begin
            pos = slot_of(r.thread_id);
            if (pos < 0) e.status = ST_MISSING;
            else drop_slot(pos);
         end
         FUNC_NEXT: begin
            if (rq_count == 0) begin
               e.status = ST_EMPTY;
            end else if (!cfg_rr_mode) begin
               e.selected_id = rq_slots[0];
            end else begin
               // rotate the last pick to the tail if it is still queued
               if (run_valid && rq_count > 1) begin
                  pos = slot_of(run_id);
                  if (pos >= 0) begin
                     drop_slot(pos);
                     rq_slots[rq_count] = run_id;
                     rq_count++;
                  end
               end
               run_id        = rq_slots[0];
               run_valid     = 1'b1;
               e.selected_id = run_id;
            end
         end
         default: ;
      endcase
   endtask

   // Check results, track register writes, predict each accepted request
   always @(posedge clock) begin : monitor
      rsp_type exp_rsp;
      if (reset) begin
         rq_count     = 0;
         run_id       = '0;
         run_valid    = 1'b0;
         cfg_capacity = CAP_RESET;
         cfg_rr_mode  = RR_MODE_RESET;
         req_taken    = 1'b0;
         for (int i = 0; i < QUEUE_DEPTH; i++) rq_slots[i] = '0;
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result: status %0d, selected_id 0x%02h",
                      rsp_item.status, rsp_item.selected_id);
               fail_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_item.status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d",
                         exp_rsp.status, rsp_item.status);
                  fail_count++;
               end
               if (rsp_item.selected_id !== exp_rsp.selected_id) begin
                  $error("selected_id: expected 0x%02h, actual 0x%02h",
                         exp_rsp.selected_id, rsp_item.selected_id);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_CAPACITY) cfg_capacity = csr_wdata[CAP_W-1:0];
            else if (csr_index == CSR_RR_MODE) cfg_rr_mode = csr_wdata[0];
         end
         req_taken = start && !busy;
         if (req_taken) begin
            accepted_count++;
            apply_request(req_item, exp_rsp);
            expected_rsps.push_back(exp_rsp);
         end
      end
   end

   // Issue pending requests with random gaps; hold a request until taken
   always @(negedge clock) begin : driver
      int roll;
      if (!reset && (!start || req_taken)) begin
         if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            req_item <= pending_reqs.pop_front();
            start    <= 1'b1;
            roll = $urandom_range(0, 99);
            if (!gaps_on || roll < 50) gap_left = 0;
            else if (roll < 85) gap_left = $urandom_range(1, 3);
            else if (roll < 97) gap_left = $urandom_range(4, 12);
            else gap_left = $urandom_range(20, 60);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("** run_queue_rr_fifo_scheduler_core: FAILED **");
         $finish;
      end
   end

   task automatic push_request(input logic [FUNC_W-1:0] func,
                               input logic [ID_W-1:0] id);
      req_type r;
      r.func      = func;
      r.thread_id = id;
      pending_reqs.push_back(r);
      issued_count++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Wait until every request is taken and answered
   task automatic wait_idle();
      do @(negedge clock);
      while (!(accepted_count == issued_count && expected_rsps.size() == 0 && !busy));
   endtask

   initial begin : stimulus
      int              cap_plan [RAND_PHASES] = '{16, 1, 31, 0, 17, 4, 16, 8, 2, 12, 3, 16};
      bit              rr_plan  [RAND_PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 1, 0, 1};
      logic [ID_W-1:0] id_pool  [24];
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0] id;
      int              eff_cap;
      int              pool_n;
      int              roll;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, unused code, duplicates, rotation, running id leaving
      push_request(FUNC_NEXT,   8'h00);
      push_request(FUNC_LEAVE,  8'h3C);
      push_request(FUNC_UNUSED, 8'hFF);
      push_request(FUNC_ENTER,  8'h00);
      push_request(FUNC_ENTER,  8'hFF);
      push_request(FUNC_ENTER,  8'h00);
      push_request(FUNC_ENTER,  8'hA5);
      push_request(FUNC_ENTER,  8'h5A);
      push_request(FUNC_NEXT,   8'hFF);
      push_request(FUNC_NEXT,   8'h00);
      push_request(FUNC_LEAVE,  8'hFF);
      push_request(FUNC_NEXT,   8'h00);
      push_request(FUNC_LEAVE,  8'h77);
      push_request(FUNC_ENTER,  8'h3C);

      // capacity below the count, duplicate ahead of full, FIFO pick
      wait_idle();
      write_reg(CSR_CAPACITY, 5'd2);
      write_reg(CSR_RR_MODE, 5'd0);
      @(posedge clock);
      push_request(FUNC_ENTER, 8'h99);
      push_request(FUNC_ENTER, 8'h5A);
      push_request(FUNC_NEXT,  8'h00);
      push_request(FUNC_NEXT,  8'h00);
      push_request(FUNC_LEAVE, 8'hA5);
      push_request(FUNC_LEAVE, 8'h00);
      push_request(FUNC_ENTER, 8'h99);
      push_request(FUNC_LEAVE, 8'h5A);
      push_request(FUNC_ENTER, 8'h99);

      // zero capacity acting as one, single entry round-robin pick
      wait_idle();
      write_reg(CSR_CAPACITY, 5'd0);
      write_reg(CSR_RR_MODE, 5'd1);
      @(posedge clock);
      push_request(FUNC_NEXT,  8'h00);
      push_request(FUNC_LEAVE, 8'h99);
      push_request(FUNC_NEXT,  8'h00);
      push_request(FUNC_ENTER, 8'h11);

      // random phases over a small per-phase id pool, with some wide noise
      for (int p = 0; p < RAND_PHASES; p++) begin
         wait_idle();
         write_reg(CSR_CAPACITY, CSR_DATA_W'(cap_plan[p]));
         write_reg(CSR_RR_MODE, {4'($urandom_range(0, 15)), rr_plan[p]});
         @(posedge clock);
         gaps_on = (p % 4 != 3);
         eff_cap = (cap_plan[p] == 0) ? 1 :
                   (cap_plan[p] > QUEUE_DEPTH) ? QUEUE_DEPTH : cap_plan[p];
         pool_n  = eff_cap + $urandom_range(1, 6);
         for (int k = 0; k < pool_n; k++) id_pool[k] = ID_W'($urandom_range(0, 255));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) func = FUNC_ENTER;
            else if (roll < 65) func = FUNC_LEAVE;
            else if (roll < 95) func = FUNC_NEXT;
            else func = FUNC_UNUSED;
            if ($urandom_range(0, 9) == 0) id = ID_W'($urandom_range(0, 255));
            else id = id_pool[$urandom_range(0, pool_n - 1)];
            push_request(func, id);
         end
      end

      wait_idle();
      repeat (50) @(negedge clock);
      if (expected_rsps.size() != 0) begin
         $error("results still awaited: %0d", expected_rsps.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("** run_queue_rr_fifo_scheduler_core: PASSED **");
      else
         $display("** run_queue_rr_fifo_scheduler_core: FAILED **");
      $finish;
   end

endmodule
